### rtl/p2c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2c_pkg
// Widths, constants, tables and helper functions shared by the parallax to
// Cartesian pipeline.
// ----------------------------------------------------------------------------
package p2c_pkg;

  localparam int CORDIC_STAGES = 24;

  localparam int PAR_W = 18;
  localparam int RA_W  = 31;
  localparam int DE_W  = 30;
  localparam int OUT_W = 28;

  // angle in Q30 before reduction, CORDIC datapath, trig outputs
  localparam int ANG_W  = 34;
  localparam int Z_W    = 33;
  localparam int XY_W   = 33;
  localparam int TRIG_W = 32;

  // divider: numerator and quotient bits, magnitude of parallax
  localparam int N_W  = 27;
  localparam int AP_W = 18;

  localparam int LAT_DIV   = N_W + 2;
  localparam int LAT_COR   = CORDIC_STAGES + 2;
  localparam int LAT_FRONT = (LAT_DIV > LAT_COR) ? LAT_DIV : LAT_COR;
  localparam int LAT_MUL   = 4;
  localparam int LAT_TOTAL = LAT_FRONT + LAT_MUL;

  localparam logic [N_W-1:0]          DIST_NUM    = 27'd83495936;
  localparam logic signed [OUT_W-1:0] OUT_MAX     = 28'sd83495936;
  localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 34'sd6746518852;
  localparam logic signed [XY_W-1:0]  GAIN_Q30    = 33'sd652032874;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
    32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic                    zero;
    logic signed [OUT_W-1:0] dist_ly;
  } dist_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'(OUT_MAX);
    lo = -34'(OUT_MAX);
    if (v > hi) return OUT_MAX;
    if (v < lo) return -OUT_MAX;
    return OUT_W'(v);
  endfunction

endpackage

### rtl/p2c_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2c_in_if
// Star record channel: parallax, right ascension and declination.
// ----------------------------------------------------------------------------
interface p2c_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [p2c_pkg::PAR_W-1:0]  parallax;
  logic        [p2c_pkg::RA_W-1:0]   right_ascension;
  logic signed [p2c_pkg::DE_W-1:0]   declination;

  modport source (output valid, parallax, right_ascension, declination, input ready);
  modport sink   (input valid, parallax, right_ascension, declination, output ready);
endinterface

### rtl/p2c_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2c_out_if
// Result channel: distance and Cartesian position in light years.
// ----------------------------------------------------------------------------
interface p2c_out_if;
  logic                              valid;
  logic                              ready;
  logic                              valid_res;
  logic signed [p2c_pkg::OUT_W-1:0]  distance;
  logic signed [p2c_pkg::OUT_W-1:0]  pos_x;
  logic signed [p2c_pkg::OUT_W-1:0]  pos_y;
  logic signed [p2c_pkg::OUT_W-1:0]  pos_z;

  modport source (output valid, valid_res, distance, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, valid_res, distance, pos_x, pos_y, pos_z, output ready);
endinterface

### rtl/p2c_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2c_div
// Pipelined restoring divider: distance = round(83495936 / |p|) with the
// sign of p, one quotient bit per stage.
// ----------------------------------------------------------------------------
module p2c_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [p2c_pkg::PAR_W-1:0]  parallax_i,
  output p2c_pkg::dist_t                    dist_o
);

  localparam int NW = p2c_pkg::N_W;
  localparam int AW = p2c_pkg::AP_W;

  logic [AW-1:0] rem_q  [NW+1];
  logic [NW-1:0] nq_q   [NW+1];
  logic [AW-1:0] ap_q   [NW+1];
  logic          neg_q  [NW+1];
  logic          zero_q [NW+1];
  p2c_pkg::dist_t dist_q;

  logic [AW-1:0] ap_d;
  logic [NW-1:0] num_d;

  always_comb begin
    ap_d  = parallax_i[AW-1] ? AW'(-parallax_i) : AW'(parallax_i);
    num_d = p2c_pkg::DIST_NUM + NW'(ap_d >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      nq_q[0]   <= num_d;
      ap_q[0]   <= ap_d;
      neg_q[0]  <= parallax_i[AW-1];
      zero_q[0] <= (parallax_i == '0);
    end
  end

  genvar k;
  generate
    for (k = 0; k < NW; k++) begin : g_step
      logic [AW:0]   t;
      logic          ge;
      logic [AW-1:0] rem_d;
      always_comb begin
        t     = {rem_q[k], nq_q[k][NW-1]};
        ge    = (t >= {1'b0, ap_q[k]});
        rem_d = ge ? AW'(t - {1'b0, ap_q[k]}) : t[AW-1:0];
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1]  <= rem_d;
          nq_q[k+1]   <= {nq_q[k][NW-2:0], ge};
          ap_q[k+1]   <= ap_q[k];
          neg_q[k+1]  <= neg_q[k];
          zero_q[k+1] <= zero_q[k];
        end
      end
    end
  endgenerate

  // apply the sign of the parallax
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q.zero    <= zero_q[NW];
      dist_q.dist_ly <= neg_q[NW] ? -p2c_pkg::OUT_W'(nq_q[NW])
                                  : p2c_pkg::OUT_W'(nq_q[NW]);
    end
  end

  assign dist_o = dist_q;

endmodule

### rtl/p2c_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2c_cordic
// Range reduction, quadrant fold and unrolled rotation-mode CORDIC giving
// cosine and sine in Q30.
// ----------------------------------------------------------------------------
module p2c_cordic (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [p2c_pkg::ANG_W-1:0]   angle_i,
  output logic signed [p2c_pkg::TRIG_W-1:0]  cos_o,
  output logic signed [p2c_pkg::TRIG_W-1:0]  sin_o
);

  localparam int CS = p2c_pkg::CORDIC_STAGES;
  localparam int XW = p2c_pkg::XY_W;
  localparam int ZW = p2c_pkg::Z_W;

  logic signed [p2c_pkg::ANG_W-1:0] a_q;
  logic signed [p2c_pkg::ANG_W-1:0] a_d;
  logic signed [p2c_pkg::ANG_W-1:0] f_d;
  logic                             fneg_d;

  logic signed [XW-1:0] x_q [CS+1];
  logic signed [XW-1:0] y_q [CS+1];
  logic signed [ZW-1:0] z_q [CS+1];
  logic                 n_q [CS+1];

  always_comb begin
    if (angle_i > p2c_pkg::PI_Q30) begin
      a_d = angle_i - p2c_pkg::TWO_PI_Q30;
    end else if (angle_i < -p2c_pkg::PI_Q30) begin
      a_d = angle_i + p2c_pkg::TWO_PI_Q30;
    end else begin
      a_d = angle_i;
    end
  end

  always_comb begin
    fneg_d = 1'b1;
    if (a_q > p2c_pkg::HALF_PI_Q30) begin
      f_d = p2c_pkg::PI_Q30 - a_q;
    end else if (a_q < -p2c_pkg::HALF_PI_Q30) begin
      f_d = -p2c_pkg::PI_Q30 - a_q;
    end else begin
      f_d    = a_q;
      fneg_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      x_q[0] <= p2c_pkg::GAIN_Q30;
      y_q[0] <= '0;
      z_q[0] <= ZW'(f_d);
      n_q[0] <= fneg_d;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CS; i++) begin : g_rot
      logic [ZW-1:0] at;
      assign at = ZW'(p2c_pkg::ATAN_Q30[i]);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!z_q[i][ZW-1]) begin
            x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
            y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
            z_q[i+1] <= z_q[i] - $signed(at);
          end else begin
            x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
            y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
            z_q[i+1] <= z_q[i] + $signed(at);
          end
          n_q[i+1] <= n_q[i];
        end
      end
    end
  endgenerate

  assign cos_o = n_q[CS] ? -p2c_pkg::TRIG_W'(x_q[CS]) : p2c_pkg::TRIG_W'(x_q[CS]);
  assign sin_o = p2c_pkg::TRIG_W'(y_q[CS]);

endmodule

### rtl/p2c_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2c_mul
// Four-stage product pipeline: distance times trig terms with Q30 rounding,
// then saturation and zero-parallax masking.
// ----------------------------------------------------------------------------
module p2c_mul (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  p2c_pkg::dist_t                     dist_i,
  input  logic signed [p2c_pkg::TRIG_W-1:0]  cos_ra_i,
  input  logic signed [p2c_pkg::TRIG_W-1:0]  sin_ra_i,
  input  logic signed [p2c_pkg::TRIG_W-1:0]  cos_de_i,
  input  logic signed [p2c_pkg::TRIG_W-1:0]  sin_de_i,
  output logic                               valid_res_o,
  output logic signed [p2c_pkg::OUT_W-1:0]   distance_o,
  output logic signed [p2c_pkg::OUT_W-1:0]   pos_x_o,
  output logic signed [p2c_pkg::OUT_W-1:0]   pos_y_o,
  output logic signed [p2c_pkg::OUT_W-1:0]   pos_z_o
);

  localparam int TW = p2c_pkg::TRIG_W;
  localparam int OW = p2c_pkg::OUT_W;
  localparam int RW = 30;
  localparam int P1W = OW + TW;
  localparam int P2W = RW + TW;

  localparam logic signed [P1W-1:0] HALF1 = P1W'(64'sd536870912);
  localparam logic signed [P2W-1:0] HALF2 = P2W'(64'sd536870912);

  p2c_pkg::dist_t       d1_q, d2_q, d3_q;
  logic signed [TW-1:0] cde1_q, cde2_q;
  logic signed [P1W-1:0] px1_q, py1_q, pz1_q;
  logic signed [RW-1:0]  rx2_q, ry2_q, rz2_q, rz3_q;
  logic signed [P2W-1:0] px3_q, py3_q;

  logic signed [P1W-1:0] px1_d, py1_d, pz1_d;
  logic signed [P2W-1:0] px3_d, py3_d;
  logic signed [P2W-1:0] tx4, ty4;

  always_comb begin
    px1_d = dist_i.dist_ly * cos_ra_i;
    py1_d = dist_i.dist_ly * sin_ra_i;
    pz1_d = dist_i.dist_ly * sin_de_i;
    px3_d = rx2_q * cde2_q;
    py3_d = ry2_q * cde2_q;
    tx4   = (px3_q + HALF2) >>> 30;
    ty4   = (py3_q + HALF2) >>> 30;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // multiply by the right ascension terms and sin(de)
      d1_q   <= dist_i;
      cde1_q <= cos_de_i;
      px1_q  <= px1_d;
      py1_q  <= py1_d;
      pz1_q  <= pz1_d;
      // round back to light years
      d2_q   <= d1_q;
      cde2_q <= cde1_q;
      rx2_q  <= RW'((px1_q + HALF1) >>> 30);
      ry2_q  <= RW'((py1_q + HALF1) >>> 30);
      rz2_q  <= RW'((pz1_q + HALF1) >>> 30);
      // multiply by cos(de)
      d3_q   <= d2_q;
      rz3_q  <= rz2_q;
      px3_q  <= px3_d;
      py3_q  <= py3_d;
      // round, saturate, mask
      valid_res_o <= !d3_q.zero;
      if (d3_q.zero) begin
        distance_o <= '0;
        pos_x_o    <= '0;
        pos_y_o    <= '0;
        pos_z_o    <= '0;
      end else begin
        distance_o <= p2c_pkg::sat_out(34'(d3_q.dist_ly));
        pos_x_o    <= p2c_pkg::sat_out(34'(tx4));
        pos_y_o    <= p2c_pkg::sat_out(34'(ty4));
        pos_z_o    <= p2c_pkg::sat_out(34'(rz3_q));
      end
    end
  end

endmodule

### rtl/parallax_to_cartesian_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallax_to_cartesian_unit
// Star record to distance and x, y, z in light years (fixed point, x256).
// ----------------------------------------------------------------------------
// Takes one record per cycle while no result waits at the output. The
// 27-step restoring divider for the distance is the longest front path; it
// runs beside the two CORDIC pipelines, and four product and rounding stages
// follow. The whole pipeline holds while a result waits at the output and
// moves as soon as it is taken. Zero parallax returns valid_res low and all
// fields zero.
module parallax_to_cartesian_unit (
  input  logic clk_i,
  input  logic rst_ni,
  p2c_in_if.sink    in_i,
  p2c_out_if.source out_o
);

  localparam int LT  = p2c_pkg::LAT_TOTAL;
  localparam int LF  = p2c_pkg::LAT_FRONT;
  localparam int DDD = LF - p2c_pkg::LAT_DIV;
  localparam int DDC = LF - p2c_pkg::LAT_COR;
  localparam int TW  = p2c_pkg::TRIG_W;

  logic          en;
  logic [LT-1:0] v_q;

  logic signed [p2c_pkg::ANG_W-1:0] ra_ang, de_ang;
  p2c_pkg::dist_t       dist_u, dist_a;
  logic signed [TW-1:0] cra_u, sra_u, cde_u, sde_u;
  logic signed [TW-1:0] cra_a, sra_a, cde_a, sde_a;

  // advance everything unless a result is waiting and not taken
  assign en         = !v_q[LT-1] || out_o.ready;
  assign in_i.ready = en;
  assign out_o.valid = v_q[LT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LT-2:0], in_i.valid};
    end
  end

  assign ra_ang = $signed({1'b0, in_i.right_ascension, 2'b00});
  assign de_ang = p2c_pkg::ANG_W'($signed({in_i.declination, 2'b00}));

  p2c_div u_div (
    .clk_i      (clk_i),
    .en_i       (en),
    .parallax_i (in_i.parallax),
    .dist_o     (dist_u)
  );

  p2c_cordic u_cordic_ra (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (ra_ang),
    .cos_o   (cra_u),
    .sin_o   (sra_u)
  );

  p2c_cordic u_cordic_de (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (de_ang),
    .cos_o   (cde_u),
    .sin_o   (sde_u)
  );

  // line up the shorter front path
  generate
    if (DDD > 0) begin : g_dly_div
      p2c_pkg::dist_t dl_q [DDD];
      always_ff @(posedge clk_i) begin
        if (en) begin
          dl_q[0] <= dist_u;
          for (int j = 1; j < DDD; j++) dl_q[j] <= dl_q[j-1];
        end
      end
      assign dist_a = dl_q[DDD-1];
    end else begin : g_no_dly_div
      assign dist_a = dist_u;
    end

    if (DDC > 0) begin : g_dly_cor
      logic signed [TW-1:0] c0_q [DDC];
      logic signed [TW-1:0] s0_q [DDC];
      logic signed [TW-1:0] c1_q [DDC];
      logic signed [TW-1:0] s1_q [DDC];
      always_ff @(posedge clk_i) begin
        if (en) begin
          c0_q[0] <= cra_u;
          s0_q[0] <= sra_u;
          c1_q[0] <= cde_u;
          s1_q[0] <= sde_u;
          for (int j = 1; j < DDC; j++) begin
            c0_q[j] <= c0_q[j-1];
            s0_q[j] <= s0_q[j-1];
            c1_q[j] <= c1_q[j-1];
            s1_q[j] <= s1_q[j-1];
          end
        end
      end
      assign cra_a = c0_q[DDC-1];
      assign sra_a = s0_q[DDC-1];
      assign cde_a = c1_q[DDC-1];
      assign sde_a = s1_q[DDC-1];
    end else begin : g_no_dly_cor
      assign cra_a = cra_u;
      assign sra_a = sra_u;
      assign cde_a = cde_u;
      assign sde_a = sde_u;
    end
  endgenerate

  p2c_mul u_mul (
    .clk_i       (clk_i),
    .en_i        (en),
    .dist_i      (dist_a),
    .cos_ra_i    (cra_a),
    .sin_ra_i    (sra_a),
    .cos_de_i    (cde_a),
    .sin_de_i    (sde_a),
    .valid_res_o (out_o.valid_res),
    .distance_o  (out_o.distance),
    .pos_x_o     (out_o.pos_x),
    .pos_y_o     (out_o.pos_y),
    .pos_z_o     (out_o.pos_z)
  );

  a_zero_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.valid_res |->
      out_o.distance == '0 && out_o.pos_x == '0 && out_o.pos_y == '0 && out_o.pos_z == '0)
    else $error("zero parallax result not cleared");

  a_dist_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.valid_res |-> out_o.distance != '0)
    else $error("valid result with zero distance");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.pos_x <= p2c_pkg::OUT_MAX && out_o.pos_x >= -p2c_pkg::OUT_MAX &&
      out_o.pos_z <= p2c_pkg::OUT_MAX && out_o.pos_z >= -p2c_pkg::OUT_MAX)
    else $error("coordinate outside saturation range");

endmodule

### tb/sv/parallax_to_cartesian_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallax_to_cartesian_unit_test
// Streams star records through the unit with random gaps and output stalls,
// and compares every result field against an in-bench fixed-point predictor
// of the distance division, the CORDIC sine/cosine and the rounded products.
// ----------------------------------------------------------------------------
module parallax_to_cartesian_unit_test;

  localparam int STALL_LIMIT = 20000;
  localparam longint PI_L      = 64'sd3373259426;
  localparam longint HALF_PI_L = 64'sd1686629713;
  localparam longint TWO_PI_L  = 64'sd6746518852;
  localparam longint OMAX      = 64'sd83495936;

  typedef struct packed {
    logic                             ok;
    logic signed [p2c_pkg::OUT_W-1:0] dist_ly;
    logic signed [p2c_pkg::OUT_W-1:0] x;
    logic signed [p2c_pkg::OUT_W-1:0] y;
    logic signed [p2c_pkg::OUT_W-1:0] z;
  } star_pos_t;

  logic clk_i;
  logic rst_ni;
  p2c_in_if  rec_if ();
  p2c_out_if pos_if ();

  parallax_to_cartesian_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (rec_if.sink),
    .out_o (pos_if.source)
  );

  star_pos_t pos_queue[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int out_stall_mode = 1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q30(longint v, longint t);
    return (v * t + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint clamp_ly(longint v);
    if (v > OMAX) return OMAX;
    if (v < -OMAX) return -OMAX;
    return v;
  endfunction

  task automatic cordic_sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, z, xs, ys;
    bit flip;
    flip = 1'b0;
    if (ang > PI_L) ang -= TWO_PI_L;
    else if (ang < -PI_L) ang += TWO_PI_L;
    if (ang > HALF_PI_L) begin
      ang = PI_L - ang;
      flip = 1'b1;
    end else if (ang < -HALF_PI_L) begin
      ang = -PI_L - ang;
      flip = 1'b1;
    end
    x = 64'sd652032874;
    y = 0;
    z = ang;
    for (int i = 0; i < p2c_pkg::CORDIC_STAGES && i < 32; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(p2c_pkg::ATAN_Q30[i]);
      end else begin
        x += ys; y -= xs; z += longint'(p2c_pkg::ATAN_Q30[i]);
      end
    end
    c = flip ? -x : x;
    s = y;
  endtask

  task automatic predict_position(input logic signed [p2c_pkg::PAR_W-1:0] par,
                                  input logic [p2c_pkg::RA_W-1:0] ra,
                                  input logic signed [p2c_pkg::DE_W-1:0] de,
                                  output star_pos_t r);
    longint p, ap, d, cra, sra, cde, sde;
    p = par;
    r = '0;
    if (p != 0) begin
      ap = p < 0 ? -p : p;
      d = (64'sd83495936 + ap / 2) / ap;
      if (p < 0) d = -d;
      cordic_sin_cos(longint'(ra) * 4, cra, sra);
      cordic_sin_cos(longint'(de) * 4, cde, sde);
      r.ok      = 1'b1;
      r.x       = p2c_pkg::OUT_W'(clamp_ly(round_q30(round_q30(d, cra), cde)));
      r.y       = p2c_pkg::OUT_W'(clamp_ly(round_q30(round_q30(d, sra), cde)));
      r.z       = p2c_pkg::OUT_W'(clamp_ly(round_q30(d, sde)));
      r.dist_ly = p2c_pkg::OUT_W'(clamp_ly(d));
    end
  endtask

  // Hold the record until it is taken; drop valid only for a gap before it.
  task automatic send_record(input logic signed [p2c_pkg::PAR_W-1:0] par,
                             input logic [p2c_pkg::RA_W-1:0] ra,
                             input logic signed [p2c_pkg::DE_W-1:0] de,
                             input bit gaps = 1'b1);
    star_pos_t exp_pos;
    int gap;
    gap = 0;
    if (gaps) gap = ($urandom_range(0, 9) < 6) ? 0 :
                    ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      rec_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    predict_position(par, ra, de, exp_pos);
    rec_if.valid           <= 1'b1;
    rec_if.parallax        <= par;
    rec_if.right_ascension <= ra;
    rec_if.declination     <= de;
    pos_queue.push_back(exp_pos);
    do @(posedge clk_i); while (!rec_if.ready);
  endtask

  task automatic send_random_record(input bit gaps);
    logic signed [p2c_pkg::PAR_W-1:0] par;
    logic [p2c_pkg::RA_W-1:0] ra;
    logic signed [p2c_pkg::DE_W-1:0] de;
    case ($urandom_range(0, 9))
      0:       par = p2c_pkg::PAR_W'($urandom);
      1:       par = p2c_pkg::PAR_W'($urandom_range(0, 20)) - p2c_pkg::PAR_W'(10);
      default: par = p2c_pkg::PAR_W'($urandom_range(0, 200000)) - p2c_pkg::PAR_W'(100000);
    endcase
    ra = ($urandom_range(0, 9) == 0) ? p2c_pkg::RA_W'($urandom) :
         p2c_pkg::RA_W'($urandom_range(0, 1686629713));
    de = ($urandom_range(0, 9) == 0) ? p2c_pkg::DE_W'($urandom) :
         p2c_pkg::DE_W'($urandom_range(0, 843314856)) - p2c_pkg::DE_W'(421657428);
    send_record(par, ra, de, gaps);
  endtask

  // Drive output ready; mode 0 never stalls, mode 1 stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_if.ready <= 1'b0;
    end else if (out_stall_mode == 0) begin
      pos_if.ready <= 1'b1;
    end else begin
      pos_if.ready <= ($urandom_range(0, 99) < 70) ? 1'b1 : ($urandom_range(0, 99) < 3) ?
                      1'b0 : pos_if.ready;
    end
  end

  always @(posedge clk_i) begin
    star_pos_t exp_pos;
    if (rst_ni && pos_if.valid && pos_if.ready) begin
      if (pos_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with nothing expected");
      end else begin
        exp_pos = pos_queue.pop_front();
        if (exp_pos.ok !== pos_if.valid_res || exp_pos.dist_ly !== pos_if.distance ||
            exp_pos.x !== pos_if.pos_x || exp_pos.y !== pos_if.pos_y ||
            exp_pos.z !== pos_if.pos_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: expected v=%0d d=%0d x=%0d y=%0d z=%0d",
                     exp_pos.ok, exp_pos.dist_ly, exp_pos.x, exp_pos.y, exp_pos.z,
                     " got v=%0d d=%0d x=%0d y=%0d z=%0d",
                     pos_if.valid_res, pos_if.distance, pos_if.pos_x, pos_if.pos_y,
                     pos_if.pos_z);
        end
      end
    end
  end

  // Watchdog: count cycles with no item moving on either side.
  always @(posedge clk_i) begin
    if ((rec_if.valid && rec_if.ready) || (pos_if.valid && pos_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_field_extremes();
    send_record(18'sd100000, 31'd0, 30'sd0);
    send_record(-18'sd100000, 31'd1686629713, 30'sd421657428);
    send_record(18'sd1, 31'd0, 30'sd0);
    send_record(-18'sd1, 31'd421657428, -30'sd421657428);
    send_record(18'sd131071, 31'h7FFFFFFF, 30'sh1FFFFFFF);
    send_record(18'sh20000, 31'h7FFFFFFF, 30'sh20000000);
    send_record(18'sd2, 31'd843314856, 30'sd210828714);
  endtask

  task automatic test_zero_parallax();
    send_record(18'sd0, 31'd0, 30'sd0);
    send_record(18'sd0, 31'h7FFFFFFF, 30'sh20000000);
    send_record(18'sd0, 31'd1234567, 30'sd7654321);
  endtask

  task automatic test_angle_folding();
    send_record(18'sd3, 31'd843314857, 30'sd421657429);
    send_record(18'sd7, 31'd1264972285, -30'sd421657429);
    send_record(-18'sd5, 31'd1686629714, 30'sd0);
    send_record(18'sd11, 31'd1700000000, 30'sd300000000);
    send_record(18'sd250, 31'd843314856, -30'sd500000000);
  endtask

  task automatic test_back_to_back();
    out_stall_mode = 0;
    for (int i = 0; i < 100; i++) send_random_record(1'b0);
    out_stall_mode = 1;
    for (int i = 0; i < 50; i++) send_random_record(1'b0);
  endtask

  task automatic test_random_records();
    for (int i = 0; i < 1400; i++) send_random_record(1'b1);
  endtask

  initial begin
    rst_ni                 = 1'b0;
    rec_if.valid           = 1'b0;
    rec_if.parallax        = '0;
    rec_if.right_ascension = '0;
    rec_if.declination     = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_zero_parallax();
    test_angle_folding();
    test_back_to_back();
    test_random_records();
    rec_if.valid <= 1'b0;
    while (pos_queue.size() != 0) @(posedge clk_i);
    repeat (p2c_pkg::LAT_TOTAL + 10) @(posedge clk_i);
    if (mismatches == 0 && pos_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
